// File: rtl/prsch_pkg.sv
// Shared types and codes for the priority round-robin scheduler.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none
package prsch_pkg;

   localparam int MAX_TASKS = 16;
   localparam int PRIO_W    = 8;
   localparam int ID_W      = 4;
   localparam int CMP_W     = 9;

   typedef enum logic [1:0] {
      ACT_CREATE    = 2'd0,
      ACT_ACTIVATE  = 2'd1,
      ACT_TERMINATE = 2'd2,
      ACT_START     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_SUSPENDED = 2'd0,
      ST_WAITING   = 2'd1,
      ST_READY     = 2'd2,
      ST_RUNNING   = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_UNKNOWN = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [ID_W-1:0]   task_id;
      logic [PRIO_W-1:0] task_priority_in;
   } req_type;

   typedef struct packed {
      logic [3:0] next_task;
      logic       switch_request;
      logic [4:0] ready_count;
      logic [1:0] status;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/priority_round_robin_scheduler_top.sv
// Top level of the priority round-robin scheduler: handshakes, result register, memories.
// Depends on prsch_pkg, prsch_ram and prsch_seq.
//
// This block is a hardware task scheduler that serves one request beat at a time. Create
// puts a suspended task into the next free slot; activate and terminate change a task's
// state and rebuild the ready queue from every non-suspended task of the most urgent
// (numerically lowest) priority, in ascending slot order; start enables scheduling.
// Every request beat gives exactly one response beat. Create, start and rejected
// requests go straight to the done state. On activate and terminate one comparator walks
// the slots, first for the best priority and then, if a live task remains, to gather the
// queue; each slot costs a priority memory read followed by a compare. Then, when
// scheduling is on and the current task is not the idle slot 0, a round-robin pick is
// made and reported with switch_request: it reads the current task's priority and,
// unless the queue is empty, pops the head and reads its priority to compare. req_ready
// is low while a request is in work. A finished response moves into the output register
// and frees the sequencer; only when that register still holds an unaccepted beat does
// the finished response wait, and req_ready stays low meanwhile.
`default_nettype none
module priority_round_robin_scheduler_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_action,
   input  wire logic [3:0] req_task_id,
   input  wire logic [7:0] req_task_priority_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_next_task,
   output logic            rsp_switch_request,
   output logic [4:0]      rsp_ready_count,
   output logic [1:0]      rsp_status
);

   localparam int IDW = prsch_pkg::ID_W;

   prsch_pkg::req_type             req;
   prsch_pkg::rsp_type             seq_rsp, rsp_ff;
   logic                           seq_idle, seq_done, take, rsp_valid_ff;
   logic                           pr_we, fq_we;
   logic [IDW-1:0]                 pr_waddr, pr_raddr, fq_waddr, fq_raddr, fq_wdata, fq_rdata;
   logic [prsch_pkg::PRIO_W-1:0]   pr_wdata, pr_rdata;

   assign req.action           = req_action;
   assign req.task_id          = req_task_id;
   assign req.task_priority_in = req_task_priority_in;

   // The output register frees the sequencer once it has captured the response.
   assign req_ready = seq_idle;
   assign take      = seq_done && (!rsp_valid_ff || rsp_ready);

   prsch_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && req_ready),
      .req      (req),
      .idle     (seq_idle),
      .done     (seq_done),
      .take     (take),
      .rsp      (seq_rsp),
      .pr_we    (pr_we),
      .pr_waddr (pr_waddr),
      .pr_wdata (pr_wdata),
      .pr_raddr (pr_raddr),
      .pr_rdata (pr_rdata),
      .fq_we    (fq_we),
      .fq_waddr (fq_waddr),
      .fq_wdata (fq_wdata),
      .fq_raddr (fq_raddr),
      .fq_rdata (fq_rdata)
   );

   // Priority of each created slot.
   prsch_ram #(.WIDTH(prsch_pkg::PRIO_W), .DEPTH(prsch_pkg::MAX_TASKS)) u_prio_ram (
      .clock    (clock),
      .we       (pr_we),
      .waddr    (pr_waddr),
      .wdata    (pr_wdata),
      .raddr    (pr_raddr),
      .rdata_ff (pr_rdata)
   );

   // Ready queue storage, a circular buffer of slot numbers.
   prsch_ram #(.WIDTH(IDW), .DEPTH(prsch_pkg::MAX_TASKS)) u_fifo_ram (
      .clock    (clock),
      .we       (fq_we),
      .waddr    (fq_waddr),
      .wdata    (fq_wdata),
      .raddr    (fq_raddr),
      .rdata_ff (fq_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= seq_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_task      = rsp_ff.next_task;
   assign rsp_switch_request = rsp_ff.switch_request;
   assign rsp_ready_count    = rsp_ff.ready_count;
   assign rsp_status         = rsp_ff.status;

endmodule
`default_nettype wire

// File: rtl/prsch_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module prsch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule
`default_nettype wire

// File: rtl/prsch_seq.sv
// Sequencer and slot-state table of the scheduler: one comparator walks the slots.
// Depends on prsch_pkg; the priority and ready-queue memories sit outside.
`default_nettype none
module prsch_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire prsch_pkg::req_type            req,
   output logic                               idle,
   output logic                               done,
   input  wire logic                          take,
   output prsch_pkg::rsp_type                 rsp,
   output logic                               pr_we,
   output logic [prsch_pkg::ID_W-1:0]         pr_waddr,
   output logic [prsch_pkg::PRIO_W-1:0]       pr_wdata,
   output logic [prsch_pkg::ID_W-1:0]         pr_raddr,
   input  wire logic [prsch_pkg::PRIO_W-1:0]  pr_rdata,
   output logic                               fq_we,
   output logic [prsch_pkg::ID_W-1:0]         fq_waddr,
   output logic [prsch_pkg::ID_W-1:0]         fq_wdata,
   output logic [prsch_pkg::ID_W-1:0]         fq_raddr,
   input  wire logic [prsch_pkg::ID_W-1:0]    fq_rdata
);

   localparam int MAX_TASKS = prsch_pkg::MAX_TASKS;
   localparam int IDW       = prsch_pkg::ID_W;
   localparam int CW        = $clog2(MAX_TASKS + 1);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_MIN_RD   = 11'b000_0000_0010,
      S_MIN_CMP  = 11'b000_0000_0100,
      S_PUSH_RD  = 11'b000_0000_1000,
      S_PUSH_CMP = 11'b000_0001_0000,
      S_DEC_RD   = 11'b000_0010_0000,
      S_DEC_POP  = 11'b000_0100_0000,
      S_DEC_RD2  = 11'b000_1000_0000,
      S_DEC_CMP  = 11'b001_0000_0000,
      S_DONE     = 11'b010_0000_0000,
      S_SPARE    = 11'b100_0000_0000
   } fsm_type;

   fsm_type                       fsm_ff, fsm_in;
   prsch_pkg::slot_state_type     slot_state_ff [MAX_TASKS];
   logic [CW-1:0]                 slot_count_ff, slot_count_in;
   logic [IDW-1:0]                head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [IDW-1:0]                cur_ff, cur_in;
   logic                          running_ff, running_in;
   logic [IDW-1:0]                idx_ff, idx_in;
   logic [prsch_pkg::PRIO_W-1:0]  best_ff, best_in;
   logic                          any_ff, any_in;
   logic [prsch_pkg::PRIO_W-1:0]  pcur_ff, pcur_in;
   logic [IDW-1:0]                nxt_ff, nxt_in;
   logic                          sw_ff, sw_in;
   prsch_pkg::status_type         status_ff, status_in;

   logic                          st_we;
   logic [IDW-1:0]                st_wa, st_ra;
   prsch_pkg::slot_state_type     st_wd, st_rd;
   logic [CW:0]                   pos_sum, pos_mod, head_sum;
   logic [IDW-1:0]                push_pos, head_inc;
   logic                          last_idx, fifo_full, go_decide;

   assign st_rd     = slot_state_ff[st_ra];
   assign pos_sum   = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign pos_mod   = (pos_sum >= (CW+1)'(MAX_TASKS)) ? pos_sum - (CW+1)'(MAX_TASKS) : pos_sum;
   assign push_pos  = IDW'(pos_mod);
   assign head_sum  = (CW+1)'(head_ff) + (CW+1)'(1);
   assign head_inc  = (head_sum >= (CW+1)'(MAX_TASKS)) ? '0 : IDW'(head_sum);
   assign last_idx  = (CW'(idx_ff) + CW'(1)) == slot_count_ff;
   assign fifo_full = count_ff == CW'(MAX_TASKS);
   assign go_decide = running_ff && (cur_ff != '0);

   always_comb begin
      fsm_in        = fsm_ff;
      slot_count_in = slot_count_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      running_in    = running_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      any_in        = any_ff;
      pcur_in       = pcur_ff;
      nxt_in        = nxt_ff;
      sw_in         = sw_ff;
      status_in     = status_ff;
      st_we         = 1'b0;
      st_wa         = idx_ff;
      st_wd         = prsch_pkg::ST_SUSPENDED;
      st_ra         = idx_ff;
      pr_we         = 1'b0;
      pr_waddr      = IDW'(slot_count_ff);
      pr_wdata      = req.task_priority_in;
      pr_raddr      = idx_ff;
      fq_we         = 1'b0;
      fq_waddr      = push_pos;
      fq_wdata      = cur_ff;
      fq_raddr      = head_ff;
      done          = 1'b0;
      case (fsm_ff)
         S_IDLE: begin
            if (start) begin
               sw_in     = 1'b0;
               status_in = prsch_pkg::STAT_OK;
               fsm_in    = S_DONE;
               case (req.action)
                  prsch_pkg::ACT_CREATE: begin
                     if (slot_count_ff >= CW'(MAX_TASKS)) begin
                        status_in = prsch_pkg::STAT_FULL;
                     end else begin
                        pr_we         = 1'b1;
                        st_we         = 1'b1;
                        st_wa         = IDW'(slot_count_ff);
                        st_wd         = prsch_pkg::ST_SUSPENDED;
                        slot_count_in = slot_count_ff + CW'(1);
                     end
                  end
                  prsch_pkg::ACT_START: begin
                     running_in = 1'b1;
                  end
                  default: begin
                     if (prsch_pkg::CMP_W'(req.task_id) >=
                         prsch_pkg::CMP_W'(slot_count_ff)) begin
                        status_in = prsch_pkg::STAT_UNKNOWN;
                     end else begin
                        st_we    = 1'b1;
                        st_wa    = IDW'(req.task_id);
                        st_wd    = (req.action == prsch_pkg::ACT_ACTIVATE) ?
                                   prsch_pkg::ST_WAITING : prsch_pkg::ST_SUSPENDED;
                        head_in  = '0;
                        count_in = '0;
                        idx_in   = '0;
                        any_in   = 1'b0;
                        fsm_in   = S_MIN_RD;
                     end
                  end
               endcase
            end
         end
         S_MIN_RD: begin
            fsm_in = S_MIN_CMP;
         end
         S_MIN_CMP: begin
            if (st_rd != prsch_pkg::ST_SUSPENDED && (!any_ff || pr_rdata < best_ff)) begin
               best_in = pr_rdata;
               any_in  = 1'b1;
            end
            if (last_idx) begin
               idx_in = '0;
               if (any_in) begin
                  fsm_in = S_PUSH_RD;
               end else if (go_decide) begin
                  fsm_in = S_DEC_RD;
               end else begin
                  fsm_in = S_DONE;
               end
            end else begin
               idx_in = idx_ff + IDW'(1);
               fsm_in = S_MIN_RD;
            end
         end
         S_PUSH_RD: begin
            fsm_in = S_PUSH_CMP;
         end
         S_PUSH_CMP: begin
            if (st_rd != prsch_pkg::ST_SUSPENDED && pr_rdata == best_ff) begin
               st_we = 1'b1;
               st_wd = prsch_pkg::ST_READY;
               if (!fifo_full) begin
                  fq_we    = 1'b1;
                  fq_wdata = idx_ff;
                  count_in = count_ff + CW'(1);
               end
            end
            if (last_idx) begin
               fsm_in = go_decide ? S_DEC_RD : S_DONE;
            end else begin
               idx_in = idx_ff + IDW'(1);
               fsm_in = S_PUSH_RD;
            end
         end
         S_DEC_RD: begin
            pr_raddr = cur_ff;
            fsm_in   = S_DEC_POP;
         end
         S_DEC_POP: begin
            st_ra   = cur_ff;
            st_wa   = cur_ff;
            pcur_in = pr_rdata;
            sw_in   = 1'b1;
            if (count_ff == '0) begin
               fsm_in = S_DONE;
               if (st_rd != prsch_pkg::ST_SUSPENDED) begin
                  st_we    = 1'b1;
                  st_wd    = prsch_pkg::ST_RUNNING;
                  fq_we    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  cur_in = '0;
               end
            end else begin
               nxt_in   = fq_rdata;
               head_in  = head_inc;
               count_in = count_ff - CW'(1);
               st_we    = 1'b1;
               st_wa    = fq_rdata;
               st_wd    = prsch_pkg::ST_RUNNING;
               fsm_in   = S_DEC_RD2;
            end
         end
         S_DEC_RD2: begin
            pr_raddr = nxt_ff;
            fsm_in   = S_DEC_CMP;
         end
         S_DEC_CMP: begin
            st_ra = cur_ff;
            st_wa = cur_ff;
            if (pcur_ff == pr_rdata && st_rd != prsch_pkg::ST_SUSPENDED) begin
               st_we = 1'b1;
               st_wd = prsch_pkg::ST_READY;
               if (!fifo_full) begin
                  fq_we    = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            cur_in = nxt_ff;
            fsm_in = S_DONE;
         end
         S_DONE: begin
            done = 1'b1;
            if (take) begin
               fsm_in = S_IDLE;
            end
         end
         default: begin
            fsm_in = S_IDLE;
         end
      endcase
   end

   assign idle               = fsm_ff == S_IDLE;
   assign rsp.next_task      = 4'(cur_ff);
   assign rsp.switch_request = sw_ff;
   assign rsp.ready_count    = 5'(count_ff);
   assign rsp.status         = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= S_IDLE;
         slot_count_ff <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         cur_ff        <= '0;
         running_ff    <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            slot_state_ff[i] <= prsch_pkg::ST_SUSPENDED;
         end
      end else begin
         fsm_ff        <= fsm_in;
         slot_count_ff <= slot_count_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         cur_ff        <= cur_in;
         running_ff    <= running_in;
         if (st_we) begin
            slot_state_ff[st_wa] <= st_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      best_ff   <= best_in;
      any_ff    <= any_in;
      pcur_ff   <= pcur_in;
      nxt_ff    <= nxt_in;
      sw_ff     <= sw_in;
      status_ff <= status_in;
   end

endmodule
`default_nettype wire

// File: rtl/prsch_checker.sv
// Port-level checks for the scheduler top level, attached by bind.
// Depends on prsch_pkg and priority_round_robin_scheduler_top.
`default_nettype none
module prsch_port_checks (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_next_task,
   input wire logic       rsp_switch_request,
   input wire logic [1:0] rsp_status
);

   // One request is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another one is in work");

   // Rejected requests never cause a switch.
   a_reject_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != prsch_pkg::STAT_OK |-> !rsp_switch_request)
      else $error("switch requested on a rejected request");

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_task)
                                  && $stable(rsp_status))
      else $error("response beat changed while stalled");

endmodule

bind priority_round_robin_scheduler_top prsch_port_checks u_prsch_port_checks (.*);
`default_nettype wire
